// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the sequencer RTL.
// Expects clk and rst_n (synchronous, active low) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or plain property.
`define SAFS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Antecedent this cycle, consequent next cycle.
`define SAFS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/safs_pkg.sv =====
// Shared types and constants of the animation frame sequencer.
// No dependencies; used by safs_ctrl, safs_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package safs_pkg;

  localparam int MAX_FRAMES_DEF = 64;
  localparam int DIV_STEPS      = 32;
  localparam int CFG_DATA_W     = 24;

  localparam logic [23:0] PERIOD_RST = 24'd1000;
  localparam logic [6:0]  FCOUNT_RST = 7'd1;
  localparam logic [7:0]  SPEED_RST  = 8'd1;
  localparam logic [15:0] MAXL_RST   = 16'd0;

  typedef enum logic [1:0] {
    CFG_PERIOD  = 2'd0,
    CFG_FCOUNT  = 2'd1,
    CFG_SPEED   = 2'd2,
    CFG_MAXLOOP = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_RESTART = 2'd2
  } act_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec_tick;
    logic exec_other;
    logic div_start;
    logic div_step;
    logic no_loop;
    logic limit_apply;
    logic walk_start;
    logic walk_step;
    logic walk_commit;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic ge_period;
    logic div_done;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/safs_ctrl.sv =====
// Sequencer controller: transaction flow, divide and table-walk sequencing.
// Depends on safs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module safs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire safs_pkg::sts_t sts,
  output safs_pkg::cmd_t     cmd
);
  import safs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_DIV,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.is_tick) begin
          cmd.exec_tick = 1'b1;
          state_nxt     = ST_CHECK;
        end else begin
          cmd.exec_other = 1'b1;
          state_nxt      = ST_DONE;
        end
      end
      ST_CHECK: begin
        if (sts.ge_period) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          cmd.no_loop    = 1'b1;
          cmd.walk_start = 1'b1;
          state_nxt      = ST_WALK;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.limit_apply = 1'b1;
          cmd.walk_start  = 1'b1;
          state_nxt       = ST_WALK;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_WALK: begin
        if (sts.walk_done) begin
          cmd.walk_commit = 1'b1;
          state_nxt       = ST_DONE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SAFS_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "ready after accept")
  `SAFS_ASSERT_NEXT(a_walk_entry, cmd.walk_start, state_r == ST_WALK, "walk not entered")

endmodule

`default_nettype wire

// ===== rtl/safs_dp.sv =====
// Sequencer datapath: config, time/loop state, restoring divider,
// frame duration memory and table walk, output register. Depends on safs_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module safs_dp #(
  parameter int MAX_FRAMES = safs_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire safs_pkg::cmd_t             cmd,
  output safs_pkg::sts_t                  sts,
  input  wire logic                       cfg_we,
  input  wire safs_pkg::cfg_idx_t         cfg_idx,
  input  wire logic [safs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [1:0]                 in_action,
  input  wire logic [15:0]                in_delta_ms,
  input  wire logic [5:0]                 in_frame_slot,
  input  wire logic [15:0]                in_frame_ms,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [6:0]                      out_current_frame,
  output logic                            out_frame_changed,
  output logic                            out_loop_event,
  output logic                            out_finish_event,
  output logic [31:0]                     out_loops_done
);
  import safs_pkg::*;

  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FW = $clog2(MAX_FRAMES + 1);
  localparam int EW = 16 + FW;
  localparam int DEPTH = 2 ** AW;

  // configuration
  logic [23:0] period_r;
  logic [6:0]  fcount_r;
  logic [7:0]  speed_r;
  logic [15:0] maxl_r;

  // captured item
  logic [1:0]  action_r;
  logic [15:0] delta_r;
  logic [5:0]  slot_r;
  logic [15:0] fms_r;

  // animation state
  logic [31:0] scaled_time_r;
  logic [31:0] loop_total_r;
  logic [6:0]  frame_pos_r;
  logic [31:0] now_r;
  logic        looped_r;
  logic        changed_r;
  logic        finished_r;

  // divider
  logic [31:0] dq_r;
  logic [23:0] drem_r;
  logic [5:0]  dcnt_r;

  // walk
  logic [FW-1:0] fidx_r;
  logic [EW-1:0] elapsed_r;
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rdata_r;

  // output register
  logic        out_valid_r;
  logic [6:0]  out_frame_r;
  logic        out_chg_r;
  logic        out_loop_r;
  logic        out_fin_r;
  logic [31:0] out_loops_r;

  logic [23:0]   period_eff;
  logic [31:0]   count32;
  logic [FW-1:0] count_w;
  logic [23:0]   prod;
  logic [25:0]   trial;
  logic          below_limit;
  logic [32:0]   upper;
  logic          hit;
  logic [FW-1:0] fidx_inc;
  logic [AW-1:0] raddr;
  logic [31:0]   slot32;
  logic [31:0]   fidx32;
  logic          mem_we;

  assign period_eff  = (period_r == '0) ? 24'd1 : period_r;
  assign count32     = (32'(fcount_r) > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES) : 32'(fcount_r);
  assign count_w     = count32[FW-1:0];
  assign prod        = 24'(delta_r) * 24'(speed_r);
  assign trial       = {1'b0, drem_r, dq_r[31]} - {2'b00, period_eff};
  assign below_limit = (maxl_r == '0) || (dq_r < 32'(maxl_r));
  assign upper       = 33'(elapsed_r) + 33'(rdata_r);
  assign hit         = (now_r >= 32'(elapsed_r)) && (33'(now_r) <= upper);
  assign fidx_inc    = fidx_r + FW'(1);
  assign raddr       = cmd.walk_start ? '0 : fidx_inc[AW-1:0];
  assign slot32      = 32'(slot_r);
  assign fidx32      = 32'(fidx_r);
  assign mem_we      = cmd.exec_other && (act_t'(action_r) == ACT_WRITE)
                       && (slot32 < 32'(MAX_FRAMES));

  assign sts.is_tick   = (act_t'(action_r) == ACT_TICK);
  assign sts.ge_period = (scaled_time_r >= 32'(period_eff));
  assign sts.div_done  = (dcnt_r == 6'(DIV_STEPS));
  assign sts.walk_done = (fidx_r == count_w) || hit;
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      fcount_r <= FCOUNT_RST;
      speed_r  <= SPEED_RST;
      maxl_r   <= MAXL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PERIOD:  period_r <= cfg_wdata;
        CFG_FCOUNT:  fcount_r <= cfg_wdata[6:0];
        CFG_SPEED:   speed_r  <= cfg_wdata[7:0];
        CFG_MAXLOOP: maxl_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= in_action;
      delta_r  <= in_delta_ms;
      slot_r   <= in_frame_slot;
      fms_r    <= in_frame_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scaled_time_r <= '0;
      loop_total_r  <= '0;
      frame_pos_r   <= '0;
    end else begin
      if (cmd.exec_tick) begin
        scaled_time_r <= scaled_time_r + 32'(prod);
      end
      if (cmd.exec_other && (act_t'(action_r) == ACT_RESTART)) begin
        scaled_time_r <= '0;
        loop_total_r  <= '0;
        frame_pos_r   <= '0;
      end
      if (cmd.limit_apply) begin
        loop_total_r <= dq_r;
      end
      if (cmd.walk_commit) begin
        frame_pos_r <= fidx32[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_other) begin
      looped_r   <= 1'b0;
      changed_r  <= 1'b0;
      finished_r <= 1'b0;
    end
    if (cmd.no_loop) begin
      now_r    <= scaled_time_r;
      looped_r <= 1'b0;
    end
    if (cmd.limit_apply) begin
      now_r    <= below_limit ? 32'(drem_r) : 32'(period_eff - 24'd1);
      looped_r <= (dq_r != loop_total_r);
    end
    if (cmd.walk_commit) begin
      changed_r  <= (fidx32[6:0] != frame_pos_r);
      finished_r <= looped_r && (loop_total_r >= 32'(maxl_r));
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dq_r   <= scaled_time_r;
      drem_r <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[25]) begin
        drem_r <= trial[23:0];
        dq_r   <= {dq_r[30:0], 1'b1};
      end else begin
        drem_r <= {drem_r[22:0], dq_r[31]};
        dq_r   <= {dq_r[30:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      fidx_r    <= '0;
      elapsed_r <= '0;
    end else if (cmd.walk_step) begin
      fidx_r    <= fidx_inc;
      elapsed_r <= elapsed_r + EW'(rdata_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot32[AW-1:0]] <= fms_r;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_frame_r <= frame_pos_r;
      out_chg_r   <= changed_r;
      out_loop_r  <= looped_r;
      out_fin_r   <= finished_r;
      out_loops_r <= loop_total_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_current_frame = out_frame_r;
  assign out_frame_changed = out_chg_r;
  assign out_loop_event    = out_loop_r;
  assign out_finish_event  = out_fin_r;
  assign out_loops_done    = out_loops_r;

  `SAFS_ASSERT(a_div_complete, cmd.limit_apply |-> dcnt_r == 6'(DIV_STEPS), "early quotient")
  `SAFS_ASSERT(a_walk_bound, cmd.walk_step |-> fidx_r < count_w, "walk past frame count")
  `SAFS_ASSERT_NEXT(a_out_loaded, cmd.out_load, out_valid_r, "result not presented")

endmodule

`default_nettype wire

// ===== rtl/sprite_animation_frame_sequencer.sv =====
// Top level of the sprite animation frame sequencer.
// Depends on safs_pkg, safs_ctrl and safs_dp.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_ready    | action, delta_ms, frame_slot, frame_ms
//  out     | out_valid / out_ready  | current_frame, frame_changed, loop_event,
//          |                        | finish_event, loops_done
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// Write, restart: accept, execute, then load the result. Tick: accept, execute, check
// the time against the period, run the 32-step restoring divider when the time reaches
// the period, walk up to frame_count table entries (frame_count capped at MAX_FRAMES)
// over the frame memory's single read port, then load the result; one item at a time.
// A held result does not block the next accept; completion waits on out_ready.
// Reset (rst_n low, synchronous) restores config, clears time state and out_valid.
`timescale 1ns / 1ps
`default_nettype none

module sprite_animation_frame_sequencer #(
  parameter int MAX_FRAMES = safs_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_action,
  input  wire logic [15:0]                     in_delta_ms,
  input  wire logic [5:0]                      in_frame_slot,
  input  wire logic [15:0]                     in_frame_ms,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [6:0]                           out_current_frame,
  output logic                                 out_frame_changed,
  output logic                                 out_loop_event,
  output logic                                 out_finish_event,
  output logic [31:0]                          out_loops_done,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire safs_pkg::cfg_idx_t              cfg_index,
  input  wire logic [safs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import safs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  safs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  safs_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_idx           (cfg_index),
    .cfg_wdata         (cfg_data),
    .in_action         (in_action),
    .in_delta_ms       (in_delta_ms),
    .in_frame_slot     (in_frame_slot),
    .in_frame_ms       (in_frame_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_current_frame (out_current_frame),
    .out_frame_changed (out_frame_changed),
    .out_loop_event    (out_loop_event),
    .out_finish_event  (out_finish_event),
    .out_loops_done    (out_loops_done)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for sprite_animation_frame_sequencer.
// Random valid/ready traffic and config phases; every result is checked against an
// in-bench model of the sequencer. Depends on safs_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module testbench;
  import safs_pkg::*;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] delta;
    logic [5:0]  slot;
    logic [15:0] fms;
  } anim_item_t;

  typedef struct packed {
    logic [6:0]  frame;
    logic        changed;
    logic        looped;
    logic        finished;
    logic [31:0] loops;
  } anim_result_t;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int TABLE_DEPTH = MAX_FRAMES_DEF;
  localparam int SETTLE_CYCLES = 110;
  localparam int MAX_REPORTS = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_action = '0;
  logic [15:0]           in_delta_ms = '0;
  logic [5:0]            in_frame_slot = '0;
  logic [15:0]           in_frame_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [6:0]            out_current_frame;
  logic                  out_frame_changed;
  logic                  out_loop_event;
  logic                  out_finish_event;
  logic [31:0]           out_loops_done;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sprite_animation_frame_sequencer i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_delta_ms       (in_delta_ms),
    .in_frame_slot     (in_frame_slot),
    .in_frame_ms       (in_frame_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_current_frame (out_current_frame),
    .out_frame_changed (out_frame_changed),
    .out_loop_event    (out_loop_event),
    .out_finish_event  (out_finish_event),
    .out_loops_done    (out_loops_done),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // sequencer model: config copy and animation state
  logic [23:0] reg_period;
  logic [6:0]  reg_fcount;
  logic [7:0]  reg_speed;
  logic [15:0] reg_maxloops;
  logic [31:0] anim_time;
  logic [31:0] loop_total;
  logic [6:0]  frame_pos;
  logic [15:0] frame_ms_table [TABLE_DEPTH];

  anim_item_t   anim_items[$];
  anim_result_t due_results[$];

  int  in_idle_pct = 0;
  int  out_stall_pct = 0;
  int  restart_pct = 4;
  int  write_pct = 12;
  bit  big_steps = 1'b0;
  bit  in_fire = 1'b0;
  int  mismatches = 0;
  int  n_ticks = 0, n_writes = 0, n_restarts = 0, n_ignored = 0;
  int  n_results = 0, n_changes = 0, n_loops = 0, n_finishes = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("testbench failed");
    $finish;
  end

  function automatic anim_result_t predict_frame(anim_item_t it);
    anim_result_t res;
    logic [31:0]  period;
    logic [31:0]  now;
    logic [31:0]  cycles;
    logic [32:0]  start_ms;
    logic [6:0]   prev;
    int           count;
    int           f;
    res = '0;
    if (it.action == ACT_TICK) begin
      period = (reg_period == '0) ? 32'd1 : {8'd0, reg_period};
      count = (reg_fcount > TABLE_DEPTH) ? TABLE_DEPTH : int'(reg_fcount);
      prev = frame_pos;
      anim_time = anim_time + it.delta * reg_speed;
      now = anim_time;
      if (now >= period) begin
        cycles = now / period;
        if (reg_maxloops == '0 || cycles < reg_maxloops) now = now % period;
        else now = period - 1;
        res.looped = (cycles != loop_total);
        loop_total = cycles;
      end
      start_ms = '0;
      f = 0;
      while (f < count && !(now >= start_ms && now <= start_ms + frame_ms_table[f])) begin
        start_ms = start_ms + frame_ms_table[f];
        f++;
      end
      frame_pos = 7'(f);
      res.changed = (frame_pos != prev);
      res.finished = res.looped && (loop_total >= reg_maxloops);
    end else if (it.action == ACT_WRITE) begin
      frame_ms_table[it.slot] = it.fms;
    end else if (it.action == ACT_RESTART) begin
      anim_time = '0;
      loop_total = '0;
      frame_pos = '0;
    end
    res.frame = frame_pos;
    res.loops = loop_total;
    return res;
  endfunction

  // input driver
  always @(negedge clk) begin
    anim_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (anim_items.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        it = anim_items.pop_front();
        in_valid <= 1'b1;
        in_action <= it.action;
        in_delta_ms <= it.delta;
        in_frame_slot <= it.slot;
        in_frame_ms <= it.fms;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // monitor: checks results, predicts accepted transactions
  always @(posedge clk) begin
    anim_result_t got, want;
    anim_item_t   it;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.frame = out_current_frame;
        got.changed = out_frame_changed;
        got.looped = out_loop_event;
        got.finished = out_finish_event;
        got.loops = out_loops_done;
        n_results++;
        n_changes += got.changed;
        n_loops += got.looped;
        n_finishes += got.finished;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with no transaction pending: frame %0d loops %0d",
                     $realtime, got.frame, got.loops);
        end else begin
          want = due_results.pop_front();
          if (got.frame !== want.frame || got.changed !== want.changed ||
              got.looped !== want.looped || got.finished !== want.finished ||
              got.loops !== want.loops) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $write("%0t: mismatch (exp/got) frame %0d/%0d changed %b/%b ", $realtime,
                     want.frame, got.frame, want.changed, got.changed);
              $display("loop %b/%b finish %b/%b loops %0d/%0d",
                       want.looped, got.looped, want.finished, got.finished,
                       want.loops, got.loops);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        it.action = in_action;
        it.delta = in_delta_ms;
        it.slot = in_frame_slot;
        it.fms = in_frame_ms;
        case (it.action)
          ACT_TICK:    n_ticks++;
          ACT_WRITE:   n_writes++;
          ACT_RESTART: n_restarts++;
          default:     n_ignored++;
        endcase
        due_results.push_back(predict_frame(it));
      end
    end
  end

  task automatic queue_item(input logic [1:0] act, input logic [15:0] d,
                            input logic [5:0] sl, input logic [15:0] ms);
    anim_item_t it;
    it.action = act;
    it.delta = d;
    it.slot = sl;
    it.fms = ms;
    anim_items.push_back(it);
  endtask

  function automatic int frames_in_use();
    return (reg_fcount > TABLE_DEPTH) ? TABLE_DEPTH : int'(reg_fcount);
  endfunction

  // frame length sized so that the frames roughly span one period
  function automatic logic [15:0] fitted_frame_ms();
    int per_eff, base;
    per_eff = (reg_period == '0) ? 1 : int'(reg_period);
    base = per_eff / ((frames_in_use() == 0) ? 1 : frames_in_use());
    if ($urandom_range(9) == 0) return '0;
    base = base / 2 + int'($urandom_range(base));
    return (base > 65535) ? 16'hFFFF : 16'(base);
  endfunction

  function automatic logic [15:0] tick_delta();
    int r, span;
    r = $urandom_range(99);
    span = (reg_period == '0) ? 1 : int'(reg_period);
    span = span / ((reg_speed == '0) ? 1 : int'(reg_speed)) / 2;
    if (span < 1) span = 1;
    if (span > 65535) span = 65535;
    if (big_steps && r < 95) return 16'($urandom_range(65535, 61440));
    if (r < 5) return '0;
    if (r < 10) return 16'hFFFF;
    if (r < 25) return 16'($urandom);
    return 16'($urandom_range(span));
  endfunction

  task automatic queue_random_items(input int n);
    int          pick;
    logic [5:0]  sl;
    logic [15:0] ms;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < restart_pct) begin
        queue_item(ACT_RESTART, 16'($urandom), 6'($urandom), 16'($urandom));
      end else if (pick < restart_pct + 3) begin
        queue_item(ACT_UNUSED, 16'($urandom), 6'($urandom), 16'($urandom));
      end else if (pick < restart_pct + 3 + write_pct) begin
        if (frames_in_use() != 0 && $urandom_range(9) < 8)
          sl = 6'($urandom_range(frames_in_use() - 1));
        else
          sl = 6'($urandom);
        ms = ($urandom_range(9) == 0) ? 16'($urandom) : fitted_frame_ms();
        queue_item(ACT_WRITE, 16'($urandom), sl, ms);
      end else begin
        queue_item(ACT_TICK, tick_delta(), 6'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic drain_all();
    do begin
      @(posedge clk);
      #1;
    end while (anim_items.size() != 0 || in_valid || due_results.size() != 0);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PERIOD:  reg_period = data[23:0];
      CFG_FCOUNT:  reg_fcount = data[6:0];
      CFG_SPEED:   reg_speed = data[7:0];
      CFG_MAXLOOP: reg_maxloops = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [23:0] per, input logic [6:0] fc,
                           input logic [7:0] spd, input logic [15:0] ml,
                           input int n, input int mode, input bit big,
                           input bit pause_mid);
    int cnt;
    drain_all();
    repeat (4) @(posedge clk);
    cfg_write(CFG_PERIOD, per);
    cfg_write(CFG_FCOUNT, {17'($urandom), fc});
    cfg_write(CFG_SPEED, {16'($urandom), spd});
    cfg_write(CFG_MAXLOOP, {8'($urandom), ml});
    @(posedge clk);
    case (mode % 4)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 55; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 55; end
      default: begin in_idle_pct = 37; out_stall_pct = 37; end
    endcase
    big_steps = big;
    restart_pct = big ? 0 : ((ml != '0) ? 8 : 4);
    write_pct = big ? 2 : 12;
    cnt = frames_in_use();
    for (int s = 0; s < cnt; s++)
      queue_item(ACT_WRITE, 16'($urandom), 6'(s), fitted_frame_ms());
    if (pause_mid) begin
      queue_random_items((n - cnt) / 2);
      drain_all();
      queue_random_items(n - cnt - (n - cnt) / 2);
    end else begin
      queue_random_items(n - cnt);
    end
  endtask

  initial begin
    reg_period = PERIOD_RST;
    reg_fcount = FCOUNT_RST;
    reg_speed = SPEED_RST;
    reg_maxloops = MAXL_RST;
    anim_time = '0;
    loop_total = '0;
    frame_pos = '0;
    foreach (frame_ms_table[i]) frame_ms_table[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    #1;

    // reset config; every table entry is written before the first tick
    queue_item(ACT_RESTART, 16'($urandom), 6'($urandom), 16'($urandom));
    queue_item(ACT_UNUSED, 16'hFFFF, 6'h3F, 16'hFFFF);
    for (int s = 0; s < TABLE_DEPTH; s++)
      queue_item(ACT_WRITE, 16'($urandom), 6'(s),
                 (s == TABLE_DEPTH - 1) ? 16'hFFFF : 16'($urandom_range(190, 60)));
    queue_item(ACT_WRITE, 16'($urandom), 6'd0, 16'd0);
    queue_item(ACT_TICK, 16'd0, 6'($urandom), 16'($urandom));
    queue_item(ACT_TICK, 16'd1, 6'($urandom), 16'($urandom));
    queue_item(ACT_WRITE, 16'($urandom), 6'd0, 16'hFFFF);
    queue_item(ACT_TICK, 16'd0, 6'($urandom), 16'($urandom));
    queue_item(ACT_TICK, 16'd998, 6'($urandom), 16'($urandom));
    queue_item(ACT_TICK, 16'd1, 6'($urandom), 16'($urandom));
    queue_item(ACT_TICK, 16'hFFFF, 6'($urandom), 16'($urandom));
    queue_item(ACT_UNUSED, 16'($urandom), 6'($urandom), 16'($urandom));
    queue_item(ACT_RESTART, 16'($urandom), 6'($urandom), 16'($urandom));
    queue_item(ACT_WRITE, 16'($urandom), 6'd0, 16'd500);
    queue_item(ACT_TICK, 16'd500, 6'($urandom), 16'($urandom));
    queue_item(ACT_TICK, 16'd1, 6'($urandom), 16'($urandom));
    queue_item(ACT_TICK, 16'd0, 6'($urandom), 16'($urandom));
    queue_item(ACT_TICK, 16'd499, 6'($urandom), 16'($urandom));

    run_phase(24'd1000, 7'd8, 8'd1, 16'd0, 90, 0, 1'b0, 1'b0);
    run_phase(24'd100, 7'd64, 8'd3, 16'd3, 90, 1, 1'b0, 1'b0);
    run_phase(24'hFFFFFF, 7'd64, 8'd255, 16'd2, 80, 2, 1'b0, 1'b0);
    // period zero, oversized frame count, huge steps until the time wraps
    run_phase(24'd0, 7'd127, 8'd255, 16'hFFFF, 330, 3, 1'b1, 1'b0);
    run_phase(24'd1, 7'd0, 8'd0, 16'd1, 40, 0, 1'b0, 1'b0);
    run_phase(24'($urandom), 7'($urandom_range(127)), 8'($urandom),
              16'($urandom_range(8)), 90, 1, 1'b0, 1'b0);
    run_phase(24'd5000, 7'd16, 8'd2, 16'd5, 100, 2, 1'b0, 1'b1);
    run_phase(24'd60, 7'd4, 8'd1, 16'd1, 60, 3, 1'b0, 1'b0);

    drain_all();
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatches += due_results.size();
    $display("Sent %0d ticks, %0d table writes, %0d restarts, %0d unused-action items",
             n_ticks, n_writes, n_restarts, n_ignored);
    $display("Checked %0d results: %0d frame changes, %0d loops, %0d finishes, %0d errors",
             n_results, n_changes, n_loops, n_finishes, mismatches);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/safs_pkg.sv
rtl/safs_ctrl.sv
rtl/safs_dp.sv
rtl/sprite_animation_frame_sequencer.sv
tb/testbench.sv
